// ===== hdl/tzds_pkg.sv =====
// Shared types, constants and calendar helpers for the time zone date shift block.
package tzds_pkg;

  localparam int YEAR_W   = 7;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int ZONE_W   = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_HOURS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EAST_ZONE  = 1'd1;

  localparam logic [ZONE_W-1:0]  ZONE_MAX       = 4'd12;
  localparam logic [HOUR_W:0]    HOURS_PER_DAY  = 6'd24;
  localparam logic [YEAR_W-1:0]  YEAR_WRAP      = 7'd100;
  localparam logic [YEAR_W-1:0]  YEAR_LAST      = 7'd99;
  localparam logic [MONTH_W-1:0] MONTH_JAN      = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB      = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR      = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN      = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP      = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV      = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC      = 4'd12;
  localparam logic [DAY_W-1:0]   DAYS_LONG      = 5'd31;
  localparam logic [DAY_W-1:0]   DAYS_SHORT     = 5'd30;
  localparam logic [DAY_W-1:0]   DAYS_FEB_LEAP  = 5'd29;
  localparam logic [DAY_W-1:0]   DAYS_FEB       = 5'd28;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } tzds_stamp_t;

  typedef struct packed {
    tzds_stamp_t stamp;
    logic        applied;
  } tzds_result_t;

  // Years count from 2000: divisible by 400, so only the two-digit year matters.
  function automatic logic leap_year(input logic [YEAR_W-1:0] yy);
    logic is_century;
    is_century = (yy == 7'd0) || (yy == YEAR_WRAP);
    return (yy[1:0] == 2'd0) && (!is_century || (yy == 7'd0));
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] mm,
                                                  input logic [YEAR_W-1:0] yy);
    logic [DAY_W-1:0] days;
    if (mm == MONTH_FEB) begin
      days = leap_year(yy) ? DAYS_FEB_LEAP : DAYS_FEB;
    end else if (mm == MONTH_APR || mm == MONTH_JUN || mm == MONTH_SEP ||
                 mm == MONTH_NOV) begin
      days = DAYS_SHORT;
    end else begin
      days = DAYS_LONG;
    end
    return days;
  endfunction

endpackage

// ===== hdl/tzds_calc.sv =====
// Combinational hour shift and one-day date step for one request.
module tzds_calc (
  input  tzds_pkg::tzds_stamp_t          stamp_i,
  input  logic [tzds_pkg::ZONE_W-1:0]    zone_hours_i,
  input  logic                           east_zone_i,
  output tzds_pkg::tzds_result_t         result_o
);
  import tzds_pkg::*;

  logic                  enable;
  logic                  valid_month;
  logic [HOUR_W:0]       hour_sum;
  logic [HOUR_W:0]       hour_wrap;
  logic [YEAR_W:0]       year_inc;
  logic [YEAR_W-1:0]     year_dec;
  logic [MONTH_W-1:0]    month_prev;
  logic [YEAR_W-1:0]     yy;
  logic [MONTH_W-1:0]    mm;
  logic [DAY_W-1:0]      dd;
  logic [HOUR_W-1:0]     hh;

  assign enable      = (zone_hours_i != '0) && (zone_hours_i <= ZONE_MAX);
  assign valid_month = (stamp_i.month >= MONTH_JAN) && (stamp_i.month <= MONTH_DEC);
  assign hour_sum    = {1'b0, stamp_i.hour} + {2'b0, zone_hours_i};
  assign hour_wrap   = {1'b0, stamp_i.hour} + HOURS_PER_DAY - {2'b0, zone_hours_i};
  assign year_inc    = {1'b0, stamp_i.year} + 8'd1;
  assign year_dec    = stamp_i.year - 7'd1;
  assign month_prev  = stamp_i.month - 4'd1;

  always_comb begin
    yy = stamp_i.year;
    mm = stamp_i.month;
    dd = stamp_i.day;
    hh = stamp_i.hour;
    if (enable) begin
      if (east_zone_i) begin
        if (hour_sum < HOURS_PER_DAY) begin
          hh = hour_sum[HOUR_W-1:0];
        end else begin
          hh = 5'(hour_sum - HOURS_PER_DAY);
          if (valid_month) begin
            if (stamp_i.day < month_days(stamp_i.month, stamp_i.year)) begin
              dd = stamp_i.day + 5'd1;
            end else begin
              dd = 5'd1;
              if (stamp_i.month == MONTH_DEC) begin
                mm = MONTH_JAN;
                yy = (year_inc >= {1'b0, YEAR_WRAP}) ? 7'(year_inc - {1'b0, YEAR_WRAP})
                                                    : year_inc[YEAR_W-1:0];
              end else begin
                mm = stamp_i.month + 4'd1;
              end
            end
          end
        end
      end else begin
        if ({1'b0, stamp_i.hour} >= {2'b0, zone_hours_i}) begin
          hh = stamp_i.hour - {1'b0, zone_hours_i};
        end else begin
          hh = hour_wrap[HOUR_W-1:0];
          if (valid_month) begin
            if (stamp_i.day > 5'd1) begin
              dd = stamp_i.day - 5'd1;
            end else if (stamp_i.month == MONTH_JAN) begin
              mm = MONTH_DEC;
              dd = DAYS_LONG;
              if (stamp_i.year == 7'd0) begin
                yy = YEAR_LAST;
              end else begin
                yy = (year_dec >= YEAR_WRAP) ? year_dec - YEAR_WRAP : year_dec;
              end
            end else begin
              mm = month_prev;
              dd = month_days(month_prev, stamp_i.year);
            end
          end
        end
      end
    end
  end

  assign result_o.stamp.year   = yy;
  assign result_o.stamp.month  = mm;
  assign result_o.stamp.day    = dd;
  assign result_o.stamp.hour   = hh;
  assign result_o.stamp.minute = stamp_i.minute;
  assign result_o.stamp.second = stamp_i.second;
  assign result_o.applied      = enable;

endmodule

// ===== hdl/time_zone_date_shift_top.sv =====
// Top level: config registers, input register, date shift and result register.
//
//   channel | ports                                         | direction
//   in      | in_valid, in_stall, in_year .. in_second      | request in
//   out     | out_valid, out_stall, out_year .. out_applied | request out
//   cfg     | cfg_we, cfg_index, cfg_wdata                  | register write
//
// One request per cycle unless out_stall holds it; the input register feeds the
// result register, with the date arithmetic in one combinational pass between them.
// Synchronous active-low reset empties both stages and loads zone 0, east.
// A stall on the output holds the result register; in_stall rises only when
// both stages are full and the output is stalled.
module time_zone_date_shift_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tzds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tzds_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [tzds_pkg::YEAR_W-1:0]      in_year,
  input  logic [tzds_pkg::MONTH_W-1:0]     in_month,
  input  logic [tzds_pkg::DAY_W-1:0]       in_day,
  input  logic [tzds_pkg::HOUR_W-1:0]      in_hour,
  input  logic [tzds_pkg::MINUTE_W-1:0]    in_minute,
  input  logic [tzds_pkg::SECOND_W-1:0]    in_second,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tzds_pkg::YEAR_W-1:0]      out_year,
  output logic [tzds_pkg::MONTH_W-1:0]     out_month,
  output logic [tzds_pkg::DAY_W-1:0]       out_day,
  output logic [tzds_pkg::HOUR_W-1:0]      out_hour,
  output logic [tzds_pkg::MINUTE_W-1:0]    out_minute,
  output logic [tzds_pkg::SECOND_W-1:0]    out_second,
  output logic                             out_applied
);
  import tzds_pkg::*;

  logic [ZONE_W-1:0] zone_hours_r;
  logic              east_zone_r;
  logic              stage_vld_r;
  logic              stage_vld_nxt;
  tzds_stamp_t       stage_r;
  logic              out_vld_r;
  logic              out_vld_nxt;
  tzds_result_t      out_r;
  tzds_result_t      calc_res;
  logic              out_open;
  logic              stage_move;
  logic              in_take;

  assign out_open   = !out_vld_r || !out_stall;
  assign stage_move = stage_vld_r && out_open;
  assign in_stall   = stage_vld_r && !out_open;
  assign in_take    = in_valid && !in_stall;

  assign stage_vld_nxt = in_take || (stage_vld_r && !stage_move);
  assign out_vld_nxt   = stage_move || (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_hours_r <= '0;
      east_zone_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ZONE_HOURS: zone_hours_r <= cfg_wdata[ZONE_W-1:0];
        CFG_EAST_ZONE:  east_zone_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      stage_vld_r <= stage_vld_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  // hold payload while stalled
  always_ff @(posedge clk) begin
    if (in_take) begin
      stage_r.year   <= in_year;
      stage_r.month  <= in_month;
      stage_r.day    <= in_day;
      stage_r.hour   <= in_hour;
      stage_r.minute <= in_minute;
      stage_r.second <= in_second;
    end
    if (stage_move) begin
      out_r <= calc_res;
    end
  end

  tzds_calc u_calc (
    .stamp_i      (stage_r),
    .zone_hours_i (zone_hours_r),
    .east_zone_i  (east_zone_r),
    .result_o     (calc_res)
  );

  assign out_valid   = out_vld_r;
  assign out_year    = out_r.stamp.year;
  assign out_month   = out_r.stamp.month;
  assign out_day     = out_r.stamp.day;
  assign out_hour    = out_r.stamp.hour;
  assign out_minute  = out_r.stamp.minute;
  assign out_second  = out_r.stamp.second;
  assign out_applied = out_r.applied;

endmodule
